// ===== rtl/g2g_pkg.sv =====
// ----------------------------------------------------------------------------
// g2g_pkg: shared definitions for the go-to-goal drive command block
// Configuration register indexes, angle constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package g2g_pkg;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_KP_ANGULAR      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ARRIVE_DISTANCE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TURN_ONLY_ANGLE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TURN_RATE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED       = 3'd4;

  localparam int CfgDataW = 31;

  // CORDIC datapath: 33-bit magnitude times 4, plus growth headroom.
  localparam int CordW = 38;
  localparam int AngW  = 24;

  localparam logic signed [AngW-1:0] ANG_PI_20   = 24'sd3294199;
  localparam logic signed [17:0]     Q313_PI     = 18'sd25736;
  localparam logic signed [17:0]     Q313_TWO_PI = 18'sd51472;
  localparam logic [27:0]            INV_GAIN_Q28 = 28'd163008218;

  // Angle step i in units of 2^-20 rad.
  function automatic logic signed [AngW-1:0] atan_step(input int unsigned i);
    logic signed [AngW-1:0] v;
    v = '0;
    unique case (i)
      0: v = 24'sd823550;
      1: v = 24'sd486170;
      2: v = 24'sd256879;
      3: v = 24'sd130396;
      4: v = 24'sd65451;
      5: v = 24'sd32757;
      6: v = 24'sd16383;
      default: begin
        if (i <= 20) v = AngW'(24'sd1 <<< (20 - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/go_to_goal_drive_command.sv =====
// Pipeline: stage 0 input register, the CORDIC stages, then stages A, B, C and D.
// Throughput: one item per cycle; busy is held low, one CORDIC stage per iteration.
// Reset: synchronous active-low rst_n clears the valid pipeline and loads the
// register defaults. The receiver cannot stall; every result shows for one cycle.
// ----------------------------------------------------------------------------
// go_to_goal_drive_command: pipelined go-to-goal heading controller
// Unrolled CORDIC vectoring for distance and bearing, then wrap, gain and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_drive_command
  import g2g_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [31:0]  in_pose_x,
  input  wire logic signed [31:0]  in_pose_y,
  input  wire logic signed [15:0]  in_pose_heading,
  input  wire logic signed [31:0]  in_goal_x,
  input  wire logic signed [31:0]  in_goal_y,
  input  wire logic signed [31:0]  in_speed_request,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output logic                     out_valid,
  output logic signed [31:0]       out_linear_cmd,
  output logic signed [15:0]       out_angular_cmd,
  output logic                     out_busy_res,
  output logic signed [15:0]       out_bearing,
  output logic signed [15:0]       out_heading_error,
  output logic [31:0]              out_distance
);

  localparam int N = CORDIC_ITERATIONS;

  logic [15:0] kp_r;
  logic [30:0] arrive_r;
  logic [14:0] turn_r;
  logic [14:0] maxw_r;
  logic [30:0] maxv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= 16'd2048;
      arrive_r <= 31'd26214;
      turn_r   <= 15'd4915;
      maxw_r   <= 15'd8192;
      maxv_r   <= 31'd19661;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP_ANGULAR:      kp_r     <= cfg_data[15:0];
        CFG_ARRIVE_DISTANCE: arrive_r <= cfg_data;
        CFG_TURN_ONLY_ANGLE: turn_r   <= cfg_data[14:0];
        CFG_MAX_TURN_RATE:   maxw_r   <= cfg_data[14:0];
        CFG_MAX_SPEED:       maxv_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Sideband carried alongside the CORDIC.
  typedef struct packed {
    logic               dxn;
    logic               dyn;
    logic               zero;
    logic signed [15:0] hd;
    logic signed [31:0] sp;
  } side_t;

  // CORDIC stages, one iteration each; entry 0 is the input register.
  logic                    cv_r [N+1];
  side_t                   cs_r [N+1];
  logic signed [CordW-1:0] cx_r [N+1];
  logic signed [CordW-1:0] cy_r [N+1];
  logic signed [AngW-1:0]  cz_r [N+1];

  // Stage 0: differences and absolute values.
  logic signed [32:0] dx_c, dy_c;

  assign dx_c = 33'(in_goal_x) - 33'(in_pose_x);
  assign dy_c = 33'(in_goal_y) - 33'(in_pose_y);

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else cv_r[0] <= start;
  end

  always_ff @(posedge clk) begin
    cs_r[0].dxn  <= dx_c[32];
    cs_r[0].dyn  <= dy_c[32];
    cs_r[0].zero <= (dx_c == '0) && (dy_c == '0);
    cs_r[0].hd   <= in_pose_heading;
    cs_r[0].sp   <= in_speed_request;
    cx_r[0]      <= CordW'({(dx_c[32] ? 33'(-dx_c) : 33'(dx_c)), 2'b00});
    cy_r[0]      <= CordW'({(dy_c[32] ? 33'(-dy_c) : 33'(dy_c)), 2'b00});
    cz_r[0]      <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [CordW-1:0] xs, ys;
    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else cv_r[i+1] <= cv_r[i];
    end
    always_ff @(posedge clk) begin
      cs_r[i+1] <= cs_r[i];
      if (!cy_r[i][CordW-1]) begin
        cx_r[i+1] <= cx_r[i] + ys;
        cy_r[i+1] <= cy_r[i] - xs;
        cz_r[i+1] <= cz_r[i] + atan_step(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - ys;
        cy_r[i+1] <= cy_r[i] + xs;
        cz_r[i+1] <= cz_r[i] - atan_step(i);
      end
    end
  end

  // Stage A: gain-correction multiply and bearing.
  logic                   va_r;
  side_t                  sa_r;
  logic signed [CordW+28:0] prod_r;
  logic signed [15:0]     bear_r;
  logic signed [AngW:0]   a_c;
  logic signed [AngW:0]   ar_c;

  always_comb begin
    a_c = (AngW+1)'(cz_r[N]);
    if (cs_r[N].dxn) a_c = (AngW+1)'(ANG_PI_20) - a_c;
    if (cs_r[N].dyn) a_c = -a_c;
    ar_c = (a_c + (AngW+1)'(64)) >>> 7;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= cv_r[N];
  end

  always_ff @(posedge clk) begin
    sa_r   <= cs_r[N];
    prod_r <= (CordW+29)'(cx_r[N]) * $signed({1'b0, INV_GAIN_Q28});
    if (cs_r[N].zero) bear_r <= '0;
    else if (ar_c > (AngW+1)'(Q313_PI)) bear_r <= 16'(Q313_PI);
    else if (ar_c < -(AngW+1)'(Q313_PI)) bear_r <= 16'(-Q313_PI);
    else bear_r <= 16'(ar_c);
  end

  // Stage B: distance rounding/saturation and heading error wrap.
  logic               vb_r;
  side_t              sb_r;
  logic [31:0]        dist_r;
  logic signed [15:0] bearb_r, err_r;
  logic signed [CordW+28:0] m_c;
  logic signed [17:0] e_c;

  assign m_c = (prod_r + (CordW+29)'(64'sd1 <<< 29)) >>> 30;
  assign e_c = 18'(bear_r) - 18'(sa_r.hd);

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    sb_r    <= sa_r;
    bearb_r <= bear_r;
    if (sa_r.zero || m_c < 0) dist_r <= '0;
    else if (m_c > (CordW+29)'(64'sd4294967295)) dist_r <= 32'hFFFF_FFFF;
    else dist_r <= 32'(m_c);
    if (e_c > Q313_PI) err_r <= 16'(e_c - Q313_TWO_PI);
    else if (e_c < -Q313_PI) err_r <= 16'(e_c + Q313_TWO_PI);
    else err_r <= 16'(e_c);
  end

  // Stage C: gain multiply, mode decisions, speed clamp.
  logic               vc_r;
  logic signed [33:0] angp_r;
  logic signed [31:0] lin_r;
  logic               busyc_r;
  logic signed [15:0] bearc_r, errc_r;
  logic [31:0]        distc_r;
  logic [15:0]        mag_c;
  logic signed [32:0] spx_c;

  assign mag_c = err_r[15] ? 16'(-err_r) : 16'(err_r);
  assign spx_c = 33'(sb_r.sp);

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    bearc_r <= bearb_r;
    errc_r  <= err_r;
    distc_r <= dist_r;
    busyc_r <= (dist_r >= {1'b0, arrive_r});
    angp_r  <= 34'(err_r) * $signed({18'd0, kp_r});
    if (mag_c > {1'b0, turn_r}) lin_r <= '0;
    else if (spx_c > $signed({2'b00, maxv_r})) lin_r <= $signed({1'b0, maxv_r});
    else if (spx_c < -$signed({2'b00, maxv_r})) lin_r <= 32'(-$signed({2'b00, maxv_r}));
    else lin_r <= sb_r.sp;
  end

  // Stage D: turn clamp and output register.
  logic signed [33:0] angs_c;
  logic signed [33:0] lim_c;

  assign angs_c = (angp_r + 34'sd2048) >>> 12;
  assign lim_c  = $signed({19'd0, maxw_r});

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vc_r;
  end

  always_ff @(posedge clk) begin
    out_bearing       <= bearc_r;
    out_heading_error <= errc_r;
    out_distance      <= distc_r;
    out_busy_res      <= busyc_r;
    if (!busyc_r) begin
      out_linear_cmd  <= '0;
      out_angular_cmd <= '0;
    end else begin
      out_linear_cmd <= lin_r;
      if (angs_c > lim_c) out_angular_cmd <= 16'(lim_c);
      else if (angs_c < -lim_c) out_angular_cmd <= 16'(-lim_c);
      else out_angular_cmd <= 16'(angs_c);
    end
  end

endmodule

`default_nettype wire
